// ----- sv/sft_pkg.sv -----
// Package: types, constants and hash function for the symmetric flow table.
package sft_pkg;

  localparam int unsigned BucketCount  = 4096;
  localparam int unsigned FlowCapacity = 16384;
  localparam int unsigned BktW   = $clog2(BucketCount);
  localparam int unsigned IdxW   = $clog2(FlowCapacity);
  localparam int unsigned CntW   = $clog2(FlowCapacity + 1);
  localparam int unsigned FlowIdxW = 14;
  // key: addr_first, addr_second, ports, proto
  localparam int unsigned KeyW   = 32 + 32 + 32 + 8;
  // entry word: key, reported, next valid, next index
  localparam int unsigned EntW   = KeyW + 1 + 1 + IdxW;
  localparam int unsigned HeadW  = 1 + IdxW;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  transport_protocol;
    logic        detected;
  } sft_in_t;

  typedef struct packed {
    logic [13:0] flow_index;
    logic        new_flow;
    logic        dropped;
    logic        report;
    logic [31:0] canon_addr_low;
    logic [31:0] canon_addr_high;
    logic [15:0] canon_port_first;
    logic [15:0] canon_port_second;
  } sft_out_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HEAD_RD, S_HEAD_WT, S_ENT_RD, S_ENT_WT, S_CHECK, S_DONE, S_OUT
  } sft_state_e;

  typedef struct packed {
    logic clear_wr;    // write empty head at clear counter
    logic clear_inc;
    logic load;        // capture input transaction
    logic head_rd;
    logic head_take;   // take head read data into cursor
    logic ent_rd;
    logic ent_take;    // compare / follow link
    logic finish;      // commit result and updates
  } sft_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic have;        // cursor valid and in range
    logic hit;
    logic guard_last;
  } sft_sts_t;

  function automatic logic [BktW-1:0] bucket_of(
    input logic [31:0] a, input logic [31:0] b,
    input logic [15:0] pa, input logic [15:0] pb, input logic [7:0] pr);
    logic [31:0] h;
    h = a ^ (b << 1) ^ ({16'd0, pa} << 3) ^ ({16'd0, pb} << 5) ^ {24'd0, pr};
    return h[BktW-1:0];
  endfunction

endpackage

// ----- sv/symmetric_flow_table.sv -----
// Top level of the symmetric flow table.
// Usage: one input transaction carries a packet's IPv4 5-tuple plus a classifier
// detected bit; one output transaction returns the flow index, new/dropped/report
// flags and the canonically ordered tuple.
// Channels use valid/stall; a transaction moves when valid is high and stall low.
// Each item reads the bucket RAM, then does one entry RAM read and compare per
// chain link visited.
// One item is in work at a time; the chain walk in the entry memory sets rate.
// The next item is taken only after the result has been accepted; while the
// receiver stalls, the result holds and in_stall_o stays high.
// After reset the bucket heads are cleared in a sweep over all 4096 buckets,
// during which in_stall_o stays high. Entries are allocated in order and never freed;
// once 16384 flows exist, misses are reported as dropped.
module symmetric_flow_table import sft_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  sft_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output sft_out_t out_data_o
);
  sft_cmd_t cmd;
  sft_sts_t sts;

  sft_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd));

  sft_datapath u_dp (
    .clk_i, .rst_ni, .in_i(in_data_i), .cmd_i(cmd), .sts_o(sts), .out_o(out_data_o));
endmodule

// ----- sv/sft_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module sft_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ----- sv/sft_datapath.sv -----
// Datapath: tuple ordering, hash, bucket and entry memories, chain cursor, result.
module sft_datapath import sft_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  sft_in_t  in_i,
  input  sft_cmd_t cmd_i,
  output sft_sts_t sts_o,
  output sft_out_t out_o
);
  logic [31:0] a_q, b_q;
  logic [15:0] pa_q, pb_q;
  logic [7:0]  pr_q;
  logic        det_q;
  logic [BktW-1:0] bkt_q;
  logic [BktW-1:0] clr_q;
  logic [CntW-1:0] used_q;
  logic [CntW-1:0] steps_q;
  logic            have_q;
  logic [IdxW-1:0] cur_q;
  logic            hit_q;
  logic [HeadW-1:0] head_q;
  sft_out_t        out_q;

  logic [31:0] a_d, b_d;
  logic [15:0] pa_d, pb_d;
  logic        swap;
  logic [HeadW-1:0] head_rdata;
  logic [EntW-1:0]  ent_rdata;
  logic [KeyW-1:0]  key;
  logic             ent_hit;
  logic             full;
  logic             rep_old;
  logic [IdxW-1:0]  new_idx;
  logic             head_we, ent_we, ent_re;
  logic [BktW-1:0]  head_waddr;
  logic [HeadW-1:0] head_wdata;
  logic [IdxW-1:0]  ent_waddr;
  logic [EntW-1:0]  ent_wdata;

  assign swap = !((in_i.src_addr < in_i.dst_addr) ||
                  (in_i.src_addr == in_i.dst_addr && in_i.src_port <= in_i.dst_port));
  assign a_d  = swap ? in_i.dst_addr : in_i.src_addr;
  assign b_d  = swap ? in_i.src_addr : in_i.dst_addr;
  assign pa_d = swap ? in_i.dst_port : in_i.src_port;
  assign pb_d = swap ? in_i.src_port : in_i.dst_port;

  assign key     = {a_q, b_q, pa_q, pb_q, pr_q};
  assign ent_hit = ent_rdata[EntW-1 -: KeyW] == key;
  assign full    = used_q >= CntW'(FlowCapacity);
  assign new_idx = used_q[IdxW-1:0];
  assign rep_old = ent_rdata[IdxW+1];

  assign head_we    = cmd_i.clear_wr || (cmd_i.finish && !hit_q && !full);
  assign head_waddr = cmd_i.clear_wr ? clr_q : bkt_q;
  assign head_wdata = cmd_i.clear_wr ? '0 : {1'b1, new_idx};

  // insert writes a full entry; a hit rewrites it with reported set when detected and not yet reported
  assign ent_we    = cmd_i.finish && (hit_q ? (det_q && !rep_old) : !full);
  assign ent_waddr = hit_q ? cur_q : new_idx;
  assign ent_wdata = hit_q ? {ent_rdata[EntW-1:IdxW+2], 1'b1, ent_rdata[IdxW:0]}
                           : {key, det_q, head_q};
  assign ent_re    = cmd_i.ent_rd;

  sft_ram #(.Width(HeadW), .Depth(BucketCount)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .re_i(cmd_i.head_rd), .raddr_i(bkt_q), .rdata_o(head_rdata));

  sft_ram #(.Width(EntW), .Depth(FlowCapacity)) u_ent (
    .clk_i, .we_i(ent_we), .waddr_i(ent_waddr), .wdata_i(ent_wdata),
    .re_i(ent_re), .raddr_i(cur_q), .rdata_o(ent_rdata));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q <= a_d; b_q <= b_d; pa_q <= pa_d; pb_q <= pb_d;
      pr_q <= in_i.transport_protocol; det_q <= in_i.detected;
      bkt_q <= bucket_of(a_d, b_d, pa_d, pb_d, in_i.transport_protocol);
    end
    if (cmd_i.head_take) begin
      head_q <= head_rdata;
      cur_q  <= head_rdata[IdxW-1:0];
    end else if (cmd_i.ent_take && !ent_hit) begin
      cur_q <= ent_rdata[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      used_q  <= '0;
      steps_q <= '0;
      have_q  <= 1'b0;
      hit_q   <= 1'b0;
      out_q   <= '0;
    end else begin
      if (cmd_i.clear_inc) clr_q <= clr_q + BktW'(1);
      if (cmd_i.load) hit_q <= 1'b0;
      if (cmd_i.head_take) begin
        have_q  <= head_rdata[HeadW-1];
        steps_q <= '0;
      end else if (cmd_i.ent_take) begin
        if (ent_hit) hit_q <= 1'b1;
        else begin
          have_q  <= ent_rdata[IdxW];
          steps_q <= steps_q + CntW'(1);
        end
      end
      if (cmd_i.finish) begin
        out_q.canon_addr_low    <= a_q;
        out_q.canon_addr_high   <= b_q;
        out_q.canon_port_first  <= pa_q;
        out_q.canon_port_second <= pb_q;
        if (hit_q) begin
          out_q.flow_index <= FlowIdxW'(cur_q);
          out_q.new_flow   <= 1'b0;
          out_q.dropped    <= 1'b0;
          out_q.report     <= det_q && !rep_old;
        end else if (full) begin
          out_q.flow_index <= '0;
          out_q.new_flow   <= 1'b0;
          out_q.dropped    <= 1'b1;
          out_q.report     <= 1'b0;
        end else begin
          out_q.flow_index <= FlowIdxW'(new_idx);
          out_q.new_flow   <= 1'b1;
          out_q.dropped    <= 1'b0;
          out_q.report     <= det_q;
          used_q           <= used_q + CntW'(1);
        end
      end
    end
  end

  assign sts_o.clear_last = clr_q == BktW'(BucketCount - 1);
  assign sts_o.have       = have_q && (32'(cur_q) < FlowCapacity);
  assign sts_o.hit        = hit_q;
  assign sts_o.guard_last = steps_q >= CntW'(FlowCapacity);
  assign out_o = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(FlowCapacity))
    else $error("used count beyond capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && !hit_q && !full |=> used_q == $past(used_q) + CntW'(1))
    else $error("insert did not advance used count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> !(out_q.dropped && out_q.new_flow))
    else $error("dropped and new together");
endmodule

// ----- sv/sft_ctrl.sv -----
// Controller: bucket clear sweep, chain walk sequencing and output handshake.
module sft_ctrl import sft_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  sft_sts_t   sts_i,
  output sft_cmd_t   cmd_o
);
  sft_state_e state_q, state_d;
  logic       ovalid_q, ovalid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:   if (sts_i.clear_last) state_d = S_IDLE;
      S_IDLE:    if (in_valid_i) state_d = S_HEAD_RD;
      S_HEAD_RD: state_d = S_HEAD_WT;
      S_HEAD_WT: state_d = S_CHECK;
      S_CHECK:   if (sts_i.hit || !sts_i.have || sts_i.guard_last) state_d = S_DONE;
                 else state_d = S_ENT_RD;
      S_ENT_RD:  state_d = S_ENT_WT;
      S_ENT_WT:  state_d = S_CHECK;
      S_DONE:    state_d = S_OUT;
      S_OUT:     if (!ovalid_q || !out_stall_i) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_CLEAR:   begin cmd_o.clear_wr = 1'b1; cmd_o.clear_inc = 1'b1; end
      S_IDLE:    cmd_o.load = in_valid_i;
      S_HEAD_RD: cmd_o.head_rd = 1'b1;
      S_HEAD_WT: cmd_o.head_take = 1'b1;
      S_ENT_RD:  cmd_o.ent_rd = 1'b1;
      S_ENT_WT:  cmd_o.ent_take = 1'b1;
      S_CHECK:   if (sts_i.hit || !sts_i.have || sts_i.guard_last) cmd_o.ent_rd = 1'b1;
      S_DONE:    cmd_o.finish = 1'b1;
      default:   ;
    endcase
  end

  // entry data read in CHECK is the matched entry (or unused) during DONE
  always_comb begin
    ovalid_d = ovalid_q;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    if (state_q == S_DONE) ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = ovalid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |=> ovalid_q)
    else $error("result not presented");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && out_stall_i |=> ovalid_q)
    else $error("stalled result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_HEAD_RD)
    else $error("load without walk");
endmodule

// ----- tb/sft_checker.sv -----
// Checker for the symmetric flow table: predicts results from accepted inputs and compares.
`timescale 1ns / 1ps
module sft_checker import sft_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  sft_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  sft_out_t out_data_i,
  output int       fail_count_o,
  output int       pending_o
);

  int unsigned head_idx [BucketCount];
  bit          head_ok  [BucketCount];
  logic [31:0] flow_a   [FlowCapacity];
  logic [31:0] flow_b   [FlowCapacity];
  logic [31:0] flow_pp  [FlowCapacity];
  logic [7:0]  flow_pr  [FlowCapacity];
  int unsigned flow_nxt [FlowCapacity];
  bit          flow_nok [FlowCapacity];
  bit          flow_rep [FlowCapacity];
  int unsigned flows_used;
  sft_out_t    expected_flows[$];

  function automatic sft_out_t lookup_flow(sft_in_t p);
    sft_out_t r;
    logic [31:0] a, b, h;
    logic [15:0] pa, pb;
    int unsigned bkt, cur, idx, n;
    bit have, hit;
    r = '0;
    hit = 0;
    idx = 0;
    if (p.src_addr < p.dst_addr ||
        (p.src_addr == p.dst_addr && p.src_port <= p.dst_port)) begin
      a = p.src_addr; b = p.dst_addr; pa = p.src_port; pb = p.dst_port;
    end else begin
      a = p.dst_addr; b = p.src_addr; pa = p.dst_port; pb = p.src_port;
    end
    h = a ^ (b << 1) ^ ({16'd0, pa} << 3) ^ ({16'd0, pb} << 5) ^ {24'd0, p.transport_protocol};
    bkt = h % BucketCount;
    have = head_ok[bkt];
    cur = head_idx[bkt];
    for (n = 0; have && n < FlowCapacity && cur < FlowCapacity; n++) begin
      if (flow_a[cur] == a && flow_b[cur] == b && flow_pp[cur] == {pa, pb} &&
          flow_pr[cur] == p.transport_protocol) begin
        hit = 1; idx = cur; break;
      end
      have = flow_nok[cur];
      cur = flow_nxt[cur];
    end
    if (!hit) begin
      if (flows_used >= FlowCapacity) begin
        r.dropped = 1;
      end else begin
        idx = flows_used;
        flow_a[idx] = a; flow_b[idx] = b; flow_pp[idx] = {pa, pb};
        flow_pr[idx] = p.transport_protocol;
        flow_nxt[idx] = head_idx[bkt]; flow_nok[idx] = head_ok[bkt];
        flow_rep[idx] = 0;
        head_idx[bkt] = idx; head_ok[bkt] = 1;
        flows_used++;
        r.new_flow = 1;
      end
    end
    if (!r.dropped && p.detected && !flow_rep[idx]) begin
      flow_rep[idx] = 1;
      r.report = 1;
    end
    r.flow_index = r.dropped ? '0 : idx[13:0];
    r.canon_addr_low = a; r.canon_addr_high = b;
    r.canon_port_first = pa; r.canon_port_second = pb;
    return r;
  endfunction

  initial begin
    foreach (head_ok[i]) head_ok[i] = 0;
    flows_used = 0;
    fail_count_o = 0;
  end

  assign pending_o = expected_flows.size();

  always @(posedge clk_i) begin
    sft_out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) expected_flows.push_back(lookup_flow(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_flows.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected result transaction %p", out_data_i);
        end else begin
          want = expected_flows.pop_front();
          if (want !== out_data_i) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10) $display("mismatch: exp %p got %p", want, out_data_i);
          end
        end
      end
    end
  end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the symmetric flow table: stimulus, timeout and verdict.
`timescale 1ns / 1ps
module tb import sft_pkg::*;;

  logic     clk = 0;
  logic     rst_n = 0;
  logic     in_valid = 0;
  logic     in_stall;
  sft_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 0;
  sft_out_t out_data;
  int       fail_count;
  int       pending;
  int       rx_mode = 0;
  sft_in_t  flow_pool[$];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  symmetric_flow_table i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  sft_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(negedge clk) begin
    case (rx_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // leaves valid high; the caller drops it when idling
  task automatic send_packet(sft_in_t p);
    in_valid <= 1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic sft_in_t random_packet();
    sft_in_t p;
    p.src_addr = $urandom; p.dst_addr = $urandom;
    p.src_port = $urandom; p.dst_port = $urandom;
    p.transport_protocol = $urandom;
    p.detected = $urandom_range(0, 1);
    return p;
  endfunction

  function automatic sft_in_t pick_packet();
    sft_in_t p, q;
    int k;
    k = $urandom_range(0, 9);
    if (flow_pool.size() > 0 && k < 6) begin
      q = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
      p = q;
      if ($urandom_range(0, 1)) begin
        p.src_addr = q.dst_addr; p.dst_addr = q.src_addr;
        p.src_port = q.dst_port; p.dst_port = q.src_port;
      end
      p.detected = ($urandom_range(0, 2) == 0);
    end else if (k == 6) begin
      p = random_packet();
      p.dst_addr = p.src_addr;
      if ($urandom_range(0, 1)) p.dst_port = p.src_port;
    end else begin
      p = random_packet();
      p.transport_protocol = $urandom_range(0, 1) ? 8'd6 : 8'd17;
      if ($urandom_range(0, 3) == 0) p.transport_protocol = $urandom;
      flow_pool.push_back(p);
    end
    return p;
  endfunction

  initial begin
    #1000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    sft_in_t p;
    int n, gap;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    p = '0; send_packet(p);
    p.detected = 1; send_packet(p);
    p = '1; send_packet(p);
    p = '1; p.detected = 0; send_packet(p);
    p = '{32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, 8'd6, 1'b0}; send_packet(p);
    p = '{32'h0A000002, 32'h0A000001, 16'd80, 16'd1234, 8'd6, 1'b1}; send_packet(p);
    p = '{32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, 8'd6, 1'b1}; send_packet(p);
    p = '{32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, 8'd17, 1'b1}; send_packet(p);
    p = '{32'h0A000005, 32'h0A000005, 16'd9, 16'd7, 8'd17, 1'b0}; send_packet(p);
    p = '{32'h0A000005, 32'h0A000005, 16'd7, 16'd9, 8'd17, 1'b1}; send_packet(p);
    p = '{32'h0A000005, 32'h0A000005, 16'd7, 16'd7, 8'd1, 1'b0}; send_packet(p);
    // same bucket, distinct flows: proto toggles low hash bits, addr bit compensates
    p = '{32'h00000003, 32'hFFFFFFFF, 16'd0, 16'd0, 8'd0, 1'b0}; send_packet(p);
    p = '{32'h00000002, 32'hFFFFFFFF, 16'd0, 16'd0, 8'd1, 1'b1}; send_packet(p);
    p = '{32'h00000003, 32'hFFFFFFFF, 16'd0, 16'd0, 8'd0, 1'b1}; send_packet(p);
    p = '{32'hFFFFFFFF, 32'h00000000, 16'hFFFF, 16'h0000, 8'hFF, 1'b1}; send_packet(p);
    in_valid <= 0;
    wait (pending == 0);
    @(negedge clk);
    n = 0;
    while (n < 700) begin
      rx_mode = (n / 200) % 3;
      gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(negedge clk);
      end
      repeat ($urandom_range(1, 16)) begin
        send_packet(pick_packet());
        n++;
      end
      if (n > 300 && n < 320) begin
        in_valid <= 0;
        wait (pending == 0);
        @(negedge clk);
      end
    end
    in_valid <= 0;
    rx_mode = 0;
    wait (pending == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
